// ===== hw/rtl/alpd_pkg.sv =====
// Shared constants, types and duty-scaling helpers for the averaged level PWM driver.
`timescale 1ns / 1ps
`default_nettype none

package alpd_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int AVG_COUNT       = 4;
  localparam int AVG_SHIFT       = $clog2(AVG_COUNT);
  localparam int IDX_W           = $clog2(AVG_COUNT);

  localparam int ONE_VOLT_CODE = 1241;
  localparam int MATCH_BASE    = 25;
  localparam int MATCH_SPAN    = 20;
  localparam int MATCH_RESET   = 25;
  localparam int MATCH_OFFSET  = MATCH_BASE - MATCH_SPAN;
  localparam int DUTY_DIV      = AVG_COUNT * ONE_VOLT_CODE;

  localparam int THR_W     = 12;
  localparam int PERIOD_W  = 8;
  localparam int MATCH_W   = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [THR_W-1:0]    LOW_THR_RESET  = THR_W'(1241);
  localparam logic [THR_W-1:0]    HIGH_THR_RESET = THR_W'(2482);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(50);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = CFG_IDX_W'(2);

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOW  = 2'd0,
    MODE_PWM  = 2'd1,
    MODE_HIGH = 2'd2
  } drive_mode_t;

  typedef struct packed {
    logic [THR_W-1:0]    low_thr;
    logic [THR_W-1:0]    high_thr;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  // largest block sum for a given sample width
  function automatic longint sum_max_f(input int sb);
    return longint'(AVG_COUNT) * ((longint'(1) << sb) - longint'(1));
  endfunction

  // reciprocal shift: 2^k above every sum times the divisor keeps the quotient exact
  function automatic int recip_shift_f(input int sb);
    return $clog2(sum_max_f(sb) * longint'(DUTY_DIV) + longint'(1));
  endfunction

  // ceil(MATCH_SPAN * 2^k / DUTY_DIV)
  function automatic longint recip_mul_f(input int sb);
    return ((longint'(MATCH_SPAN) << recip_shift_f(sb)) + longint'(DUTY_DIV - 1)) / DUTY_DIV;
  endfunction

  function automatic int quot_w_f(input int sb);
    return $clog2(longint'(MATCH_SPAN) * sum_max_f(sb) / DUTY_DIV + longint'(1));
  endfunction

  // sum times reciprocal; the quotient sits in the top bits
  function automatic int prod_w_f(input int sb);
    return recip_shift_f(sb) + quot_w_f(sb);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/alpd_cfg.sv =====
// Configuration registers: thresholds and PWM period.
`timescale 1ns / 1ps
`default_nettype none

module alpd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [alpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [alpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output alpd_pkg::cfg_t                     cfg_o
);
  import alpd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr  <= LOW_THR_RESET;
      cfg_r.high_thr <= HIGH_THR_RESET;
      cfg_r.period   <= PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_THR:  cfg_r.low_thr  <= cfg_data[THR_W-1:0];
        REG_HIGH_THR: cfg_r.high_thr <= cfg_data[THR_W-1:0];
        REG_PERIOD:   cfg_r.period   <= cfg_data[PERIOD_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/alpd_pre.sv =====
// Input register; also scales each sample by the duty reciprocal.
`timescale 1ns / 1ps
`default_nettype none

module alpd_pre #(
  parameter int SAMPLE_BITS = alpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic                                            in_req_type,
  input  logic [SAMPLE_BITS-1:0]                          in_sample_value,
  output logic                                            p_valid,
  input  logic                                            p_take,
  output logic                                            p_req_type,
  output logic [SAMPLE_BITS-1:0]                          p_sample,
  output logic [alpd_pkg::prod_w_f(SAMPLE_BITS)-1:0]      p_prod
);
  import alpd_pkg::*;

  localparam int     PROD_W    = prod_w_f(SAMPLE_BITS);
  localparam longint RECIP_MUL = recip_mul_f(SAMPLE_BITS);

  logic              p_valid_r;
  logic              p_req_type_r;
  logic [SAMPLE_BITS-1:0] p_sample_r;
  logic [PROD_W-1:0] p_prod_r;
  logic              accept;

  assign in_ready = !p_valid_r || p_take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (accept) begin
      p_valid_r <= 1'b1;
    end else if (p_take) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_req_type_r <= in_req_type;
      p_sample_r   <= in_sample_value;
      p_prod_r     <= PROD_W'(in_sample_value) * PROD_W'(RECIP_MUL);
    end
  end

  assign p_valid    = p_valid_r;
  assign p_req_type = p_req_type_r;
  assign p_sample   = p_sample_r;
  assign p_prod     = p_prod_r;

endmodule

`default_nettype wire

// ===== hw/rtl/alpd_core.sv =====
// Averaging, threshold decision, PWM counter and the result register.
`timescale 1ns / 1ps
`default_nettype none

module alpd_core #(
  parameter int SAMPLE_BITS = alpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  alpd_pkg::cfg_t                              cfg_i,
  input  logic                                        p_valid,
  output logic                                        p_take,
  input  logic                                        p_req_type,
  input  logic [SAMPLE_BITS-1:0]                      p_sample,
  input  logic [alpd_pkg::prod_w_f(SAMPLE_BITS)-1:0]  p_prod,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic                                        out_pin_level,
  output logic [alpd_pkg::MODE_W-1:0]                 out_drive_mode,
  output logic [alpd_pkg::MATCH_W-1:0]                out_duty_match
);
  import alpd_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + AVG_SHIFT;
  localparam int PROD_W = prod_w_f(SAMPLE_BITS);
  localparam int Q_W    = quot_w_f(SAMPLE_BITS);
  localparam int CMP_W  = (SUM_W > THR_W + AVG_SHIFT) ? SUM_W : THR_W + AVG_SHIFT;
  localparam int MW     = ((Q_W > MATCH_W) ? Q_W : MATCH_W) + 1;

  // averaging state
  logic [IDX_W-1:0]   sample_index_r, sample_index_nxt;
  logic [SUM_W-1:0]   partial_sum_r, partial_sum_nxt;
  logic [PROD_W-1:0]  pm_r, pm_nxt;       // partial_sum scaled by the reciprocal
  logic [SUM_W-1:0]   held_sum_r, held_sum_nxt;
  logic [Q_W-1:0]     held_q_r, held_q_nxt;
  // PWM state
  logic               running_r, running_nxt;
  logic [MATCH_W-1:0] tick_count_r, tick_count_nxt;
  logic [MATCH_W-1:0] match_r, match_nxt;
  logic               pin_r, pin_nxt;
  // result register
  logic               out_valid_r;
  logic               out_pin_r;
  drive_mode_t        out_mode_r;
  logic [MATCH_W-1:0] out_match_r;

  logic               fire;
  logic               block_end;
  logic [SUM_W-1:0]   sum_new;
  logic [PROD_W-1:0]  prod_new;
  logic [CMP_W-1:0]   held_c, low_c, high_c;
  logic [MW-1:0]      duty_w;
  logic [MATCH_W-1:0] tick_inc;
  drive_mode_t        mode_nxt;

  assign fire   = p_valid && (!out_valid_r || out_ready);
  assign p_take = fire;

  assign block_end = (sample_index_r == IDX_W'(AVG_COUNT - 1));
  assign sum_new   = partial_sum_r + SUM_W'(p_sample);
  assign prod_new  = pm_r + p_prod;
  assign tick_inc  = tick_count_r + MATCH_W'(1);

  always_comb begin
    sample_index_nxt = sample_index_r;
    partial_sum_nxt  = partial_sum_r;
    pm_nxt           = pm_r;
    held_sum_nxt     = held_sum_r;
    held_q_nxt       = held_q_r;
    running_nxt      = running_r;
    tick_count_nxt   = tick_count_r;
    match_nxt        = match_r;
    pin_nxt          = pin_r;
    held_c           = '0;
    low_c            = CMP_W'(cfg_i.low_thr) << AVG_SHIFT;
    high_c           = CMP_W'(cfg_i.high_thr) << AVG_SHIFT;
    duty_w           = '0;

    if (p_req_type == REQ_SAMPLE) begin
      if (block_end) begin
        held_sum_nxt     = sum_new;
        held_q_nxt       = prod_new[PROD_W-1 -: Q_W];
        partial_sum_nxt  = '0;
        pm_nxt           = '0;
        sample_index_nxt = '0;
      end else begin
        partial_sum_nxt  = sum_new;
        pm_nxt           = prod_new;
        sample_index_nxt = sample_index_r + IDX_W'(1);
      end

      held_c = CMP_W'(held_sum_nxt);
      duty_w = MW'(held_q_nxt) + MW'(MATCH_OFFSET);
      if (held_c < low_c) begin
        running_nxt = 1'b0;
        pin_nxt     = 1'b0;
      end else if (held_c > high_c) begin
        running_nxt = 1'b0;
        pin_nxt     = 1'b1;
      end else begin
        running_nxt = 1'b1;
        // saturate the match count at its register width
        match_nxt   = (duty_w > MW'((1 << MATCH_W) - 1)) ? {MATCH_W{1'b1}}
                                                         : duty_w[MATCH_W-1:0];
      end
    end else if (running_r) begin
      tick_count_nxt = tick_inc;
      if (tick_inc == match_r) begin
        pin_nxt = 1'b0;
      end
      if (tick_inc == cfg_i.period) begin
        pin_nxt        = 1'b1;
        tick_count_nxt = '0;
      end
    end
  end

  always_comb begin
    if (running_nxt) begin
      mode_nxt = MODE_PWM;
    end else if (pin_nxt) begin
      mode_nxt = MODE_HIGH;
    end else begin
      mode_nxt = MODE_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      partial_sum_r  <= '0;
      pm_r           <= '0;
      held_sum_r     <= '0;
      held_q_r       <= '0;
      running_r      <= 1'b1;
      tick_count_r   <= '0;
      match_r        <= MATCH_W'(MATCH_RESET);
      pin_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (fire) begin
        sample_index_r <= sample_index_nxt;
        partial_sum_r  <= partial_sum_nxt;
        pm_r           <= pm_nxt;
        held_sum_r     <= held_sum_nxt;
        held_q_r       <= held_q_nxt;
        running_r      <= running_nxt;
        tick_count_r   <= tick_count_nxt;
        match_r        <= match_nxt;
        pin_r          <= pin_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pin_r   <= pin_nxt;
      out_mode_r  <= mode_nxt;
      out_match_r <= match_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_level  = out_pin_r;
  assign out_drive_mode = out_mode_r;
  assign out_duty_match = out_match_r;

  // a block that has just started carries no partial sum
  a_block_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_index_r == '0) |-> (partial_sum_r == '0 && pm_r == '0))
    else $error("partial sum not cleared at block start");

  // the fourth sample of a block moves the sum into the held value
  a_block_end_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && p_req_type == REQ_SAMPLE && block_end) |=>
      (sample_index_r == '0 && held_sum_r == $past(sum_new)))
    else $error("block end did not update held sum");

  // a tick while the PWM is stopped leaves counter and pin alone
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && p_req_type == REQ_TICK && !running_r) |=>
      ($stable(tick_count_r) && $stable(pin_r)))
    else $error("stopped PWM changed on tick");

  // every processed request leaves a result waiting
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_valid_r && out_pin_r == pin_r))
    else $error("processed request has no result");

endmodule

`default_nettype wire

// ===== hw/rtl/averaged_level_to_pwm_driver_core.sv =====
// Top level of the averaged level to PWM driver.
//
// Usage:
//   Input requests (in_valid/in_ready) are either a one-microsecond tick
//   (in_req_type = 0) or a converter sample (in_req_type = 1, in_sample_value).
//   Every request yields exactly one result (out_valid/out_ready): the pin
//   level, the drive mode (forced low, PWM, forced high) and the match count.
//   Config writes (cfg_valid/cfg_index/cfg_data) set the low threshold, the
//   high threshold and the PWM period; cfg_ready is always high and an unknown
//   index is dropped. Write config only while no request is in flight.
// Timing:
//   One request per cycle sustained while out_ready is high. A request passes
//   through the input register, then the state update into the result
//   register. The per-sample reciprocal multiply sits ahead of the input
//   register; the state update loop does one request per cycle.
// Reset (rst_n low, synchronous): sums cleared, PWM enabled, counter zero,
//   match 25, pin low, thresholds and period back to their defaults.
// Stall: with out_ready low the result holds; in_ready stays high until the
//   input register is also occupied.
`timescale 1ns / 1ps
`default_nettype none

module averaged_level_to_pwm_driver_core #(
  parameter int SAMPLE_BITS = alpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [SAMPLE_BITS-1:0]            in_sample_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_pin_level,
  output logic [alpd_pkg::MODE_W-1:0]       out_drive_mode,
  output logic [alpd_pkg::MATCH_W-1:0]      out_duty_match,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [alpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import alpd_pkg::*;

  localparam int PROD_W = prod_w_f(SAMPLE_BITS);

  cfg_t                   cfg;
  logic                   p_valid;
  logic                   p_take;
  logic                   p_req_type;
  logic [SAMPLE_BITS-1:0] p_sample;
  logic [PROD_W-1:0]      p_prod;

  alpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  alpd_pre #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pre (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_sample_value (in_sample_value),
    .p_valid         (p_valid),
    .p_take          (p_take),
    .p_req_type      (p_req_type),
    .p_sample        (p_sample),
    .p_prod          (p_prod)
  );

  alpd_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg),
    .p_valid        (p_valid),
    .p_take         (p_take),
    .p_req_type     (p_req_type),
    .p_sample       (p_sample),
    .p_prod         (p_prod),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pin_level  (out_pin_level),
    .out_drive_mode (out_drive_mode),
    .out_duty_match (out_duty_match)
  );

endmodule

`default_nettype wire
